// ===== hw/rtl/lcd4_pkg.sv =====
// Shared types and the control program for the 4-bit LCD bus sequencer.
// No dependencies. The sequencer top level imports this package.
package lcd4_pkg;

    localparam int PC_W = 5;

    // Command codes on the action field.
    localparam logic [2:0] ACT_INSTR = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_INIT  = 3'd2;
    localparam logic [2:0] ACT_ADDR  = 3'd3;
    localparam logic [2:0] ACT_ROW   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SETTLE   = 3'd0;
    localparam logic [2:0] CFG_POWER_UP = 3'd1;
    localparam logic [2:0] CFG_WAKE_GAP = 3'd2;
    localparam logic [2:0] CFG_FSET     = 3'd3;
    localparam logic [2:0] CFG_EMODE    = 3'd4;
    localparam logic [2:0] CFG_DCTL     = 3'd5;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_BYTE = 5'd0;
    localparam logic [PC_W-1:0] PC_INIT = 5'd4;

    // Nibble source.
    localparam logic [2:0] NIB_ZERO = 3'd0;
    localparam logic [2:0] NIB_WAKE = 3'd1;
    localparam logic [2:0] NIB_MODE = 3'd2;
    localparam logic [2:0] NIB_HI   = 3'd3;
    localparam logic [2:0] NIB_LO   = 3'd4;

    // Byte source for the high and low nibble sources.
    localparam logic [2:0] BYT_CMD   = 3'd0;
    localparam logic [2:0] BYT_FSET  = 3'd1;
    localparam logic [2:0] BYT_EMODE = 3'd2;
    localparam logic [2:0] BYT_DCTL  = 3'd3;
    localparam logic [2:0] BYT_CLEAR = 3'd4;

    // Hold source.
    localparam logic [1:0] HLD_SETTLE = 2'd0;
    localparam logic [1:0] HLD_POWER  = 2'd1;
    localparam logic [1:0] HLD_WAKE   = 2'd2;

    localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
    localparam logic [3:0] MODE4_NIBBLE  = 4'h2;
    localparam logic [7:0] CLEAR_CODE    = 8'h01;
    localparam logic [7:0] SET_DDRAM_BIT = 8'h80;

    typedef struct packed {
        logic [2:0] nib_sel;
        logic [2:0] byte_sel;
        logic       en;
        logic [1:0] hold_sel;
        logic       last;
    } t_uop;

    function automatic t_uop uop(input logic [2:0] nib, input logic [2:0] byt,
                                 input logic en, input logic [1:0] hold,
                                 input logic last);
        t_uop w;
        w.nib_sel  = nib;
        w.byte_sel = byt;
        w.en       = en;
        w.hold_sel = hold;
        w.last     = last;
        return w;
    endfunction

    // One control word per output pin state. A byte write runs from PC_BYTE,
    // the init sequence from PC_INIT; the last flag ends the command.
    function automatic t_uop rom_word(input logic [PC_W-1:0] pc);
        t_uop w;
        w = uop(NIB_ZERO, BYT_CMD, 1'b0, HLD_SETTLE, 1'b1);
        case (pc)
            5'd0:  w = uop(NIB_HI, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd1:  w = uop(NIB_HI, BYT_CMD, 1'b0, HLD_SETTLE, 1'b0);
            5'd2:  w = uop(NIB_LO, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd3:  w = uop(NIB_LO, BYT_CMD, 1'b0, HLD_SETTLE, 1'b1);
            5'd4:  w = uop(NIB_ZERO, BYT_CMD, 1'b0, HLD_POWER, 1'b0);
            5'd5:  w = uop(NIB_WAKE, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd6:  w = uop(NIB_WAKE, BYT_CMD, 1'b0, HLD_WAKE, 1'b0);
            5'd7:  w = uop(NIB_WAKE, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd8:  w = uop(NIB_WAKE, BYT_CMD, 1'b0, HLD_WAKE, 1'b0);
            5'd9:  w = uop(NIB_WAKE, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd10: w = uop(NIB_WAKE, BYT_CMD, 1'b0, HLD_WAKE, 1'b0);
            5'd11: w = uop(NIB_MODE, BYT_CMD, 1'b1, HLD_SETTLE, 1'b0);
            5'd12: w = uop(NIB_MODE, BYT_CMD, 1'b0, HLD_SETTLE, 1'b0);
            5'd13: w = uop(NIB_HI, BYT_FSET, 1'b1, HLD_SETTLE, 1'b0);
            5'd14: w = uop(NIB_HI, BYT_FSET, 1'b0, HLD_SETTLE, 1'b0);
            5'd15: w = uop(NIB_LO, BYT_FSET, 1'b1, HLD_SETTLE, 1'b0);
            5'd16: w = uop(NIB_LO, BYT_FSET, 1'b0, HLD_SETTLE, 1'b0);
            5'd17: w = uop(NIB_HI, BYT_EMODE, 1'b1, HLD_SETTLE, 1'b0);
            5'd18: w = uop(NIB_HI, BYT_EMODE, 1'b0, HLD_SETTLE, 1'b0);
            5'd19: w = uop(NIB_LO, BYT_EMODE, 1'b1, HLD_SETTLE, 1'b0);
            5'd20: w = uop(NIB_LO, BYT_EMODE, 1'b0, HLD_SETTLE, 1'b0);
            5'd21: w = uop(NIB_HI, BYT_DCTL, 1'b1, HLD_SETTLE, 1'b0);
            5'd22: w = uop(NIB_HI, BYT_DCTL, 1'b0, HLD_SETTLE, 1'b0);
            5'd23: w = uop(NIB_LO, BYT_DCTL, 1'b1, HLD_SETTLE, 1'b0);
            5'd24: w = uop(NIB_LO, BYT_DCTL, 1'b0, HLD_SETTLE, 1'b0);
            5'd25: w = uop(NIB_HI, BYT_CLEAR, 1'b1, HLD_SETTLE, 1'b0);
            5'd26: w = uop(NIB_HI, BYT_CLEAR, 1'b0, HLD_SETTLE, 1'b0);
            5'd27: w = uop(NIB_LO, BYT_CLEAR, 1'b1, HLD_SETTLE, 1'b0);
            5'd28: w = uop(NIB_LO, BYT_CLEAR, 1'b0, HLD_SETTLE, 1'b1);
            default: w = uop(NIB_ZERO, BYT_CMD, 1'b0, HLD_SETTLE, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        case (row)
            2'd0: b = 8'h00;
            2'd1: b = 8'h40;
            2'd2: b = 8'h14;
            2'd3: b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_4bit_bus_sequencer.sv =====
// Character LCD 4-bit bus sequencer: a step counter walks a control program
// and one output register holds each pin state. Depends on lcd4_pkg.
//
// The request is registered into the step counter, and the first pin state
// then into the output register. Throughput: one pin state per cycle while
// the output is taken; a new request is taken the cycle after the last
// control word is issued. Unused actions are taken and dropped, no output.
// Reset (synchronous, active low) loads the register defaults and idles.
module char_lcd_4bit_bus_sequencer
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_byte_value,
    input  logic [6:0]  i_ddram_address,
    input  logic [1:0]  i_row_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_data_nibble,
    output logic        o_register_select,
    output logic        o_enable_line,
    output logic [9:0]  o_hold_ms,
    output logic        o_last
);

    logic [3:0]      r_settle;
    logic [9:0]      r_power_up;
    logic [7:0]      r_wake_gap;
    logic [7:0]      r_fset;
    logic [7:0]      r_emode;
    logic [7:0]      r_dctl;

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_cmd_byte;
    logic            r_rs;

    logic            r_out_valid;
    logic [3:0]      r_nib;
    logic            r_out_rs;
    logic            r_en;
    logic [9:0]      r_hold;
    logic            r_last;

    t_uop            uw;
    logic [7:0]      sel_byte;
    logic [3:0]      n_nib;
    logic [9:0]      n_hold;
    logic [7:0]      n_cmd_byte;
    logic            in_take;
    logic            step;

    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && !r_busy;
    assign step        = r_busy && (!r_out_valid || i_out_ready);
    assign uw          = rom_word(r_pc);

    always_comb begin
        case (uw.byte_sel)
            BYT_CMD:   sel_byte = r_cmd_byte;
            BYT_FSET:  sel_byte = r_fset;
            BYT_EMODE: sel_byte = r_emode;
            BYT_DCTL:  sel_byte = r_dctl;
            BYT_CLEAR: sel_byte = CLEAR_CODE;
            default:   sel_byte = r_cmd_byte;
        endcase
        case (uw.nib_sel)
            NIB_ZERO: n_nib = 4'h0;
            NIB_WAKE: n_nib = WAKE_NIBBLE;
            NIB_MODE: n_nib = MODE4_NIBBLE;
            NIB_HI:   n_nib = sel_byte[7:4];
            NIB_LO:   n_nib = sel_byte[3:0];
            default:  n_nib = 4'h0;
        endcase
        case (uw.hold_sel)
            HLD_SETTLE: n_hold = {6'd0, r_settle};
            HLD_POWER:  n_hold = r_power_up;
            HLD_WAKE:   n_hold = {6'd0, r_settle} + {2'd0, r_wake_gap};
            default:    n_hold = {6'd0, r_settle};
        endcase
        case (i_action)
            ACT_ADDR: n_cmd_byte = {1'b0, i_ddram_address} | SET_DDRAM_BIT;
            ACT_ROW:  n_cmd_byte = row_base(i_row_index) | SET_DDRAM_BIT;
            default:  n_cmd_byte = i_byte_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle   <= 4'd1;
            r_power_up <= 10'd400;
            r_wake_gap <= 8'd30;
            r_fset     <= 8'h28;
            r_emode    <= 8'h06;
            r_dctl     <= 8'h0C;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SETTLE:   r_settle   <= i_cfg_data[3:0];
                CFG_POWER_UP: r_power_up <= i_cfg_data;
                CFG_WAKE_GAP: r_wake_gap <= i_cfg_data[7:0];
                CFG_FSET:     r_fset     <= i_cfg_data[7:0];
                CFG_EMODE:    r_emode    <= i_cfg_data[7:0];
                CFG_DCTL:     r_dctl     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_BYTE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                // Unused action codes are taken and dropped.
                case (i_action)
                    ACT_INSTR, ACT_DATA, ACT_ADDR, ACT_ROW: begin
                        r_busy <= 1'b1;
                        r_pc   <= PC_BYTE;
                    end
                    ACT_INIT: begin
                        r_busy <= 1'b1;
                        r_pc   <= PC_INIT;
                    end
                    default: r_busy <= 1'b0;
                endcase
            end else if (step) begin
                r_pc <= r_pc + 1'b1;
                if (uw.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd_byte <= n_cmd_byte;
            r_rs       <= (i_action == ACT_DATA);
        end
        if (step) begin
            r_nib    <= n_nib;
            r_out_rs <= r_rs;
            r_en     <= uw.en;
            r_hold   <= n_hold;
            r_last   <= uw.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_nibble     = r_nib;
    assign o_register_select = r_out_rs;
    assign o_enable_line     = r_en;
    assign o_hold_ms         = r_hold;
    assign o_last            = r_last;

endmodule
